// ----- hdl/abv_pkg.sv -----
// ----------------------------------------------------------------------------
// abv_pkg
// Shared constants and tables for the vertex angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package abv_pkg;

    // Default parameter values
    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    // Minimum length register
    localparam int MIN_LEN_W = 16;

    // Normalised components stay below 2^NORM_BITS in magnitude
    localparam int NORM_BITS = 17;
    localparam int NORM_W    = NORM_BITS + 1;

    // Cosine scale (Q1.16) and quotient width of the divider
    localparam int COS_ONE = 65536;
    localparam int COS_W   = 17;
    localparam int Q_BITS  = 18;

    // CORDIC
    localparam int CORDIC_STEPS = 20;
    localparam int ZSCALE_BITS  = 20;
    localparam int Z_W          = 30;
    localparam int CORD_W       = 20;

    // Arctangent of 2^-i in degrees, scaled by 2^20
    function automatic logic signed [Z_W-1:0] atan_deg(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 30'sd47185920;
            1:       r = 30'sd27855475;
            2:       r = 30'sd14718068;
            3:       r = 30'sd7471121;
            4:       r = 30'sd3750058;
            5:       r = 30'sd1876857;
            6:       r = 30'sd938658;
            7:       r = 30'sd469357;
            8:       r = 30'sd234682;
            9:       r = 30'sd117342;
            10:      r = 30'sd58671;
            11:      r = 30'sd29335;
            12:      r = 30'sd14668;
            13:      r = 30'sd7334;
            14:      r = 30'sd3667;
            15:      r = 30'sd1833;
            16:      r = 30'sd917;
            17:      r = 30'sd458;
            18:      r = 30'sd229;
            19:      r = 30'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/abv_isqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// abv_isqrt_pipe
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module abv_isqrt_pipe #(
    parameter int IN_W = 36
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [IN_W-1:0]     radicand,
    output logic      [IN_W/2-1:0]   root
);

    localparam int RW   = IN_W / 2;
    localparam int REMW = RW + 2;

    logic [REMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [IN_W-1:0] val_reg  [RW-1];

    genvar s;
    generate
        for (s = 0; s < RW; s++) begin : g_step
            logic [REMW-1:0] rem_prev;
            logic [RW-1:0]   root_prev;
            logic [IN_W-1:0] val_prev;
            logic [REMW+1:0] acc;
            logic [REMW+1:0] trial;
            logic [REMW-1:0] rem_next;
            logic [RW-1:0]   root_next;

            if (s == 0) begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign val_prev  = radicand;
            end else begin : g_rest
                assign rem_prev  = rem_reg[s-1];
                assign root_prev = root_reg[s-1];
                assign val_prev  = val_reg[s-1];
            end

            // bring down two radicand bits, try root*4+1
            always_comb
            begin
                acc   = {rem_prev, val_prev[IN_W-1:IN_W-2]};
                trial = (REMW+2)'({root_prev, 2'b01});
                if (acc >= trial)
                begin
                    rem_next  = REMW'(acc - trial);
                    root_next = {root_prev[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REMW'(acc);
                    root_next = {root_prev[RW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                end
            end

            if (s < RW - 1) begin : g_val
                always_ff @(posedge clk)
                begin
                    if (en)
                        val_reg[s] <= val_prev << 2;
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];

endmodule

`default_nettype wire

// ----- hdl/angle_between_3d_vectors.sv -----
// Throughput: one transaction per cycle; the whole pipeline holds while a
// result waits at the output register (three square roots, the divider and
// the CORDIC are one-step-per-stage pipelines).
// Reset: valid bits clear, min_length returns to 1; data registers keep
// whatever they hold.
// ----------------------------------------------------------------------------
// angle_between_3d_vectors
// Angle at a vertex between two 3D vectors, in degrees, by dot product,
// pipelined division and a CORDIC arc cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_between_3d_vectors #(
    parameter int COORD_WIDTH     = abv_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = abv_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]       a_x,
    input  wire logic signed [COORD_WIDTH-1:0]       a_y,
    input  wire logic signed [COORD_WIDTH-1:0]       a_z,
    input  wire logic signed [COORD_WIDTH-1:0]       vertex_x,
    input  wire logic signed [COORD_WIDTH-1:0]       vertex_y,
    input  wire logic signed [COORD_WIDTH-1:0]       vertex_z,
    input  wire logic signed [COORD_WIDTH-1:0]       c_x,
    input  wire logic signed [COORD_WIDTH-1:0]       c_y,
    input  wire logic signed [COORD_WIDTH-1:0]       c_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [8+ANGLE_FRAC_BITS-1:0]             angle_deg,
    output logic                                     degenerate,
    input  wire logic                                cfg_we,
    input  wire logic [abv_pkg::MIN_LEN_W-1:0]       cfg_wdata
);

    import abv_pkg::*;

    localparam int DW      = COORD_WIDTH + 1;
    localparam int MW      = COORD_WIDTH + 1;
    localparam int SHW     = $clog2(MW + 1);
    localparam int CMPW    = (MW > MIN_LEN_W) ? MW : MIN_LEN_W;
    localparam int SQ16_W  = 2 * MIN_LEN_W;
    localparam int SSUM_W  = SQ16_W + 2;
    localparam int PROD_W  = 2 * NORM_W;
    localparam int SQ_IN_W = 36;
    localparam int SQ_RW   = SQ_IN_W / 2;
    localparam int DOT_W   = 37;
    localparam int ABS_W   = 36;
    localparam int DEN_W   = 2 * SQ_RW;
    localparam int NUM_W   = ABS_W + 16;
    localparam int REM_W   = NUM_W + 1;
    localparam int SIN_IN_W = 34;
    localparam int SIN_RW  = SIN_IN_W / 2;
    localparam int ANG_W   = 8 + ANGLE_FRAC_BITS;
    localparam int RSH     = ZSCALE_BITS - ANGLE_FRAC_BITS;
    localparam int TOTAL   = 5 + SQ_RW + 1 + Q_BITS + 2 + SIN_RW + 1 + CORDIC_STEPS + 1;

    localparam logic [ANG_W-1:0]      DEG_ANGLE = ANG_W'(180) << ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] Z_MAX     = Z_W'(180) << ZSCALE_BITS;
    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90) << ZSCALE_BITS;
    localparam logic [Z_W-1:0]        Z_RND     = Z_W'(1) << (RSH - 1);

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves as one, held by the output register
    // ------------------------------------------------------------------
    logic             en;
    logic [TOTAL-1:0] vld_reg;

    assign en       = !vld_reg[TOTAL-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
    end

    // ------------------------------------------------------------------
    // Configuration: min_length and its square
    // ------------------------------------------------------------------
    logic [MIN_LEN_W-1:0] min_length_reg;
    logic [SQ16_W-1:0]    msq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LEN_W'(1);
            msq_reg        <= SQ16_W'(1);
        end
        else
        begin
            if (cfg_we)
                min_length_reg <= cfg_wdata;
            msq_reg <= SQ16_W'(min_length_reg) * SQ16_W'(min_length_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: difference vectors u = A - V, w = C - V
    // ------------------------------------------------------------------
    logic signed [DW-1:0] u1_reg [3];
    logic signed [DW-1:0] w1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg[0] <= DW'(a_x) - DW'(vertex_x);
            u1_reg[1] <= DW'(a_y) - DW'(vertex_y);
            u1_reg[2] <= DW'(a_z) - DW'(vertex_z);
            w1_reg[0] <= DW'(c_x) - DW'(vertex_x);
            w1_reg[1] <= DW'(c_y) - DW'(vertex_y);
            w1_reg[2] <= DW'(c_z) - DW'(vertex_z);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes, zero / long tests, normalising shift
    // ------------------------------------------------------------------
    logic signed [DW-1:0]  u2_reg [3];
    logic signed [DW-1:0]  w2_reg [3];
    logic [MIN_LEN_W-1:0]  m16u2_reg [3];
    logic [MIN_LEN_W-1:0]  m16w2_reg [3];
    logic                  zu2_reg, zw2_reg, bu2_reg, bw2_reg;
    logic [SHW-1:0]        shu2_reg, shw2_reg;

    logic [MW-1:0]         magu [3];
    logic [MW-1:0]         magw [3];
    logic [MW-1:0]         oru, orw;
    logic                  bigu_next, bigw_next;
    logic [SHW-1:0]        shu_next, shw_next;

    always_comb
    begin
        int blu;
        int blw;
        blu = 0;
        blw = 0;
        oru = '0;
        orw = '0;
        bigu_next = 1'b0;
        bigw_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            magu[i] = u1_reg[i][DW-1] ? MW'(-u1_reg[i]) : MW'(u1_reg[i]);
            magw[i] = w1_reg[i][DW-1] ? MW'(-w1_reg[i]) : MW'(w1_reg[i]);
            oru = oru | magu[i];
            orw = orw | magw[i];
            if (CMPW'(magu[i]) >= CMPW'(min_length_reg))
                bigu_next = 1'b1;
            if (CMPW'(magw[i]) >= CMPW'(min_length_reg))
                bigw_next = 1'b1;
        end
        for (int b = 0; b < MW; b++)
        begin
            if (oru[b])
                blu = b + 1;
            if (orw[b])
                blw = b + 1;
        end
        shu_next = (blu > NORM_BITS) ? SHW'(blu - NORM_BITS) : '0;
        shw_next = (blw > NORM_BITS) ? SHW'(blw - NORM_BITS) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u2_reg[i]    <= u1_reg[i];
                w2_reg[i]    <= w1_reg[i];
                m16u2_reg[i] <= MIN_LEN_W'(magu[i]);
                m16w2_reg[i] <= MIN_LEN_W'(magw[i]);
            end
            zu2_reg  <= (oru == '0);
            zw2_reg  <= (orw == '0);
            bu2_reg  <= bigu_next;
            bw2_reg  <= bigw_next;
            shu2_reg <= shu_next;
            shw2_reg <= shw_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: apply normalising shift, squares for the short test
    // ------------------------------------------------------------------
    logic signed [NORM_W-1:0] nu3_reg [3];
    logic signed [NORM_W-1:0] nw3_reg [3];
    logic [SQ16_W-1:0]        squ3_reg [3];
    logic [SQ16_W-1:0]        sqw3_reg [3];
    logic                     zu3_reg, zw3_reg, bu3_reg, bw3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nu3_reg[i]  <= NORM_W'(u2_reg[i] >>> shu2_reg);
                nw3_reg[i]  <= NORM_W'(w2_reg[i] >>> shw2_reg);
                squ3_reg[i] <= SQ16_W'(m16u2_reg[i]) * SQ16_W'(m16u2_reg[i]);
                sqw3_reg[i] <= SQ16_W'(m16w2_reg[i]) * SQ16_W'(m16w2_reg[i]);
            end
            zu3_reg <= zu2_reg;
            zw3_reg <= zw2_reg;
            bu3_reg <= bu2_reg;
            bw3_reg <= bw2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: short decision, component products
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] puu4_reg [3];
    logic signed [PROD_W-1:0] pww4_reg [3];
    logic signed [PROD_W-1:0] puw4_reg [3];
    logic                     deg4_reg;

    logic [SSUM_W-1:0] ssu, ssw;
    logic              shortu, shortw;

    always_comb
    begin
        ssu = SSUM_W'(squ3_reg[0]) + SSUM_W'(squ3_reg[1]) + SSUM_W'(squ3_reg[2]);
        ssw = SSUM_W'(sqw3_reg[0]) + SSUM_W'(sqw3_reg[1]) + SSUM_W'(sqw3_reg[2]);
        shortu = zu3_reg || (!bu3_reg && (ssu < SSUM_W'(msq_reg)));
        shortw = zw3_reg || (!bw3_reg && (ssw < SSUM_W'(msq_reg)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                puu4_reg[i] <= nu3_reg[i] * nu3_reg[i];
                pww4_reg[i] <= nw3_reg[i] * nw3_reg[i];
                puw4_reg[i] <= nu3_reg[i] * nw3_reg[i];
            end
            deg4_reg <= shortu || shortw;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: squared lengths and dot product
    // ------------------------------------------------------------------
    logic [SQ_IN_W-1:0]      su5_reg, sw5_reg;
    logic signed [DOT_W-1:0] dot5_reg;
    logic                    deg5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            su5_reg  <= SQ_IN_W'($unsigned(puu4_reg[0])) + SQ_IN_W'($unsigned(puu4_reg[1]))
                      + SQ_IN_W'($unsigned(puu4_reg[2]));
            sw5_reg  <= SQ_IN_W'($unsigned(pww4_reg[0])) + SQ_IN_W'($unsigned(pww4_reg[1]))
                      + SQ_IN_W'($unsigned(pww4_reg[2]));
            dot5_reg <= DOT_W'(puw4_reg[0]) + DOT_W'(puw4_reg[1]) + DOT_W'(puw4_reg[2]);
            deg5_reg <= deg4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Lengths by square root; dot and flag ride alongside
    // ------------------------------------------------------------------
    logic [SQ_RW-1:0]        lu, lw;
    logic signed [DOT_W-1:0] dotd_reg [SQ_RW];
    logic                    degd_reg [SQ_RW];

    abv_isqrt_pipe #(.IN_W(SQ_IN_W)) u_sqrt_u (
        .clk      (clk),
        .en       (en),
        .radicand (su5_reg),
        .root     (lu)
    );

    abv_isqrt_pipe #(.IN_W(SQ_IN_W)) u_sqrt_w (
        .clk      (clk),
        .en       (en),
        .radicand (sw5_reg),
        .root     (lw)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dotd_reg[0] <= dot5_reg;
            degd_reg[0] <= deg5_reg;
            for (int j = 1; j < SQ_RW; j++)
            begin
                dotd_reg[j] <= dotd_reg[j-1];
                degd_reg[j] <= degd_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Denominator and dot magnitude
    // ------------------------------------------------------------------
    logic [DEN_W-1:0] den_reg;
    logic [ABS_W-1:0] absdot_reg;
    logic             negd_reg, degn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg    <= DEN_W'(lu) * DEN_W'(lw);
            absdot_reg <= dotd_reg[SQ_RW-1][DOT_W-1] ? ABS_W'(-dotd_reg[SQ_RW-1])
                                                      : ABS_W'(dotd_reg[SQ_RW-1]);
            negd_reg   <= dotd_reg[SQ_RW-1][DOT_W-1];
            degn_reg   <= degd_reg[SQ_RW-1];
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, MSB first
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  drem_reg [Q_BITS];
    logic [DEN_W-1:0]  dden_reg [Q_BITS];
    logic [Q_BITS-1:0] dq_reg   [Q_BITS];
    logic              dneg_reg [Q_BITS];
    logic              ddeg_reg [Q_BITS];

    genvar j;
    generate
        for (j = 0; j < Q_BITS; j++) begin : g_div
            logic [NUM_W-1:0]  rem_prev;
            logic [DEN_W-1:0]  den_prev;
            logic [Q_BITS-1:0] q_prev;
            logic              neg_prev, deg_prev;
            logic [REM_W-1:0]  trial;
            logic [NUM_W-1:0]  rem_next;
            logic [Q_BITS-1:0] q_next;

            if (j == 0) begin : g_first
                assign rem_prev = {absdot_reg, 16'b0};
                assign den_prev = den_reg;
                assign q_prev   = '0;
                assign neg_prev = negd_reg;
                assign deg_prev = degn_reg;
            end else begin : g_rest
                assign rem_prev = drem_reg[j-1];
                assign den_prev = dden_reg[j-1];
                assign q_prev   = dq_reg[j-1];
                assign neg_prev = dneg_reg[j-1];
                assign deg_prev = ddeg_reg[j-1];
            end

            always_comb
            begin
                trial  = REM_W'(den_prev) << (Q_BITS - 1 - j);
                q_next = q_prev;
                if (REM_W'(rem_prev) >= trial)
                begin
                    rem_next = NUM_W'(REM_W'(rem_prev) - trial);
                    q_next[Q_BITS-1-j] = 1'b1;
                end
                else
                begin
                    rem_next = rem_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[j] <= rem_next;
                    dden_reg[j] <= den_prev;
                    dq_reg[j]   <= q_next;
                    dneg_reg[j] <= neg_prev;
                    ddeg_reg[j] <= deg_prev;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Cosine clamp, then sine squared
    // ------------------------------------------------------------------
    logic [COS_W-1:0]    qc_reg;
    logic                negc_reg, degc_reg;
    logic [SIN_IN_W-1:0] sinsq_reg;
    logic [COS_W-1:0]    qs_reg;
    logic                negs_reg, degs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qc_reg    <= (dq_reg[Q_BITS-1] > Q_BITS'(COS_ONE)) ? COS_W'(COS_ONE)
                                                               : COS_W'(dq_reg[Q_BITS-1]);
            negc_reg  <= dneg_reg[Q_BITS-1];
            degc_reg  <= ddeg_reg[Q_BITS-1];
            sinsq_reg <= (SIN_IN_W'(1) << 32) - SIN_IN_W'(SIN_IN_W'(qc_reg) * SIN_IN_W'(qc_reg));
            qs_reg    <= qc_reg;
            negs_reg  <= negc_reg;
            degs_reg  <= degc_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sine by square root; cosine and flags ride alongside
    // ------------------------------------------------------------------
    logic [SIN_RW-1:0] sinv;
    logic [COS_W-1:0]  qsd_reg   [SIN_RW];
    logic              negsd_reg [SIN_RW];
    logic              degsd_reg [SIN_RW];

    abv_isqrt_pipe #(.IN_W(SIN_IN_W)) u_sqrt_sin (
        .clk      (clk),
        .en       (en),
        .radicand (sinsq_reg),
        .root     (sinv)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qsd_reg[0]   <= qs_reg;
            negsd_reg[0] <= negs_reg;
            degsd_reg[0] <= degs_reg;
            for (int k = 1; k < SIN_RW; k++)
            begin
                qsd_reg[k]   <= qsd_reg[k-1];
                negsd_reg[k] <= negsd_reg[k-1];
                degsd_reg[k] <= degsd_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring; a negative cosine starts rotated by 90 degrees
    // ------------------------------------------------------------------
    logic signed [CORD_W-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CORD_W-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]    cz_reg [CORDIC_STEPS+1];
    logic                     cdeg_reg [CORDIC_STEPS+1];
    logic                     cpos;

    assign cpos = !negsd_reg[SIN_RW-1] || (qsd_reg[SIN_RW-1] == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cpos)
            begin
                cx_reg[0] <= CORD_W'(qsd_reg[SIN_RW-1]);
                cy_reg[0] <= CORD_W'(sinv);
                cz_reg[0] <= '0;
            end
            else
            begin
                cx_reg[0] <= CORD_W'(sinv);
                cy_reg[0] <= CORD_W'(qsd_reg[SIN_RW-1]);
                cz_reg[0] <= Z_QUARTER;
            end
            cdeg_reg[0] <= degsd_reg[SIN_RW-1];
        end
    end

    genvar c;
    generate
        for (c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (cy_reg[c] > 0)
                    begin
                        cx_reg[c+1] <= cx_reg[c] + (cy_reg[c] >>> c);
                        cy_reg[c+1] <= cy_reg[c] - (cx_reg[c] >>> c);
                        cz_reg[c+1] <= cz_reg[c] + atan_deg(c);
                    end
                    else
                    begin
                        cx_reg[c+1] <= cx_reg[c] - (cy_reg[c] >>> c);
                        cy_reg[c+1] <= cy_reg[c] + (cx_reg[c] >>> c);
                        cz_reg[c+1] <= cz_reg[c] - atan_deg(c);
                    end
                    cdeg_reg[c+1] <= cdeg_reg[c];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Clamp to 0..180, round, output register
    // ------------------------------------------------------------------
    logic signed [Z_W-1:0] zc;
    logic [Z_W-1:0]        zr;
    logic [ANG_W-1:0]      angle_next;
    logic [ANG_W-1:0]      angle_reg;
    logic                  deg_reg;

    always_comb
    begin
        zc = cz_reg[CORDIC_STEPS];
        if (zc < 0)
            zc = '0;
        if (zc > Z_MAX)
            zc = Z_MAX;
        zr = ($unsigned(zc) + Z_RND) >> RSH;
        angle_next = cdeg_reg[CORDIC_STEPS] ? DEG_ANGLE : ANG_W'(zr);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
            deg_reg   <= cdeg_reg[CORDIC_STEPS];
        end
    end

    assign out_valid  = vld_reg[TOTAL-1];
    assign angle_deg  = angle_reg;
    assign degenerate = deg_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_deg_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> angle_deg == DEG_ANGLE)
        else $error("degenerate result without 180 degree angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_deg <= DEG_ANGLE)
        else $error("angle above 180 degrees");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_cos_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5 + SQ_RW + 1 + Q_BITS] |-> qc_reg <= COS_W'(COS_ONE))
        else $error("cosine outside unit range");

endmodule

`default_nettype wire
